// File: rtl/biq_pkg.sv
package biq_pkg;

    // Fixed field and datapath widths
    localparam int SMP_W      = 16;
    localparam int COEF_W     = 24;
    localparam int ST_W       = 48;
    localparam int PROD_W     = COEF_W + SMP_W;
    localparam int ACC_W      = ST_W + 2;
    localparam int NUM_COEFFS = 5;
    localparam int ACT_W      = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int STEP_W     = 4;

    // Request commands
    localparam logic [1:0] CMD_FILTER = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Coefficient slots within a section
    localparam logic [2:0] COEF_B0 = 3'd0;
    localparam logic [2:0] COEF_B1 = 3'd1;
    localparam logic [2:0] COEF_B2 = 3'd2;
    localparam logic [2:0] COEF_A1 = 3'd3;
    localparam logic [2:0] COEF_A2 = 3'd4;

    // Delay state slots within a section
    localparam logic ST_Z0 = 1'b0;
    localparam logic ST_Z1 = 1'b1;

    // Program addresses
    localparam logic [STEP_W-1:0] STEP_FETCH    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LOAD_Z0  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ACC_B0X  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ROUND    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MUL_A1   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_WR_Z0    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_LOAD_B2X = 4'd6;
    localparam logic [STEP_W-1:0] STEP_WR_Z1    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_EMIT     = 4'd8;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [SMP_W-1:0]  sample;
        logic [2:0]               section;
        logic [2:0]               coeff_index;
        logic signed [COEF_W-1:0] coeff_value;
    } req_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] filtered_sample;
        logic                    overflow;
    } res_t;

    typedef enum logic {
        MUL_X,
        MUL_Y
    } mul_sel_t;

    typedef enum logic [1:0] {
        BASE_ZERO,
        BASE_ACC,
        BASE_STATE
    } acc_base_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB
    } acc_op_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_mode_t;

    // One control word of the program
    typedef struct packed {
        logic       coef_rd;
        logic [2:0] coef_idx;
        logic       st_rd;
        logic       st_wr;
        logic       st_k;
        mul_sel_t   mul_sel;
        acc_base_t  base;
        acc_op_t    op;
        logic       acc_en;
        logic       y_en;
        logic       loop_end;
        logic       emit;
    } ucode_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic   start;
        logic   advance;
        ucode_t uc;
    } ctrl_t;

    localparam ucode_t UC_NOP = '{
        coef_rd:  1'b0,
        coef_idx: COEF_B0,
        st_rd:    1'b0,
        st_wr:    1'b0,
        st_k:     ST_Z0,
        mul_sel:  MUL_X,
        base:     BASE_ACC,
        op:       OP_NONE,
        acc_en:   1'b0,
        y_en:     1'b0,
        loop_end: 1'b0,
        emit:     1'b0
    };

    // Program ROM: one section per pass of steps FETCH..WR_Z1, then EMIT
    function automatic ucode_t biq_ucode(input logic [STEP_W-1:0] step);
        ucode_t uc;
        uc = UC_NOP;
        case (step)
            STEP_FETCH:
            begin
                uc.coef_rd  = 1'b1;
                uc.coef_idx = COEF_B0;
                uc.st_rd    = 1'b1;
                uc.st_k     = ST_Z0;
            end
            STEP_LOAD_Z0:
            begin
                uc.coef_rd  = 1'b1;
                uc.coef_idx = COEF_B1;
                uc.st_rd    = 1'b1;
                uc.st_k     = ST_Z1;
                uc.mul_sel  = MUL_X;
                uc.base     = BASE_STATE;
                uc.op       = OP_NONE;
                uc.acc_en   = 1'b1;
            end
            STEP_ACC_B0X:
            begin
                uc.mul_sel = MUL_X;
                uc.base    = BASE_ACC;
                uc.op      = OP_ADD;
                uc.acc_en  = 1'b1;
            end
            STEP_ROUND:
            begin
                uc.coef_rd  = 1'b1;
                uc.coef_idx = COEF_A1;
                uc.y_en     = 1'b1;
                uc.base     = BASE_STATE;
                uc.op       = OP_ADD;
                uc.acc_en   = 1'b1;
            end
            STEP_MUL_A1:
            begin
                uc.coef_rd  = 1'b1;
                uc.coef_idx = COEF_B2;
                uc.mul_sel  = MUL_Y;
            end
            STEP_WR_Z0:
            begin
                uc.coef_rd  = 1'b1;
                uc.coef_idx = COEF_A2;
                uc.mul_sel  = MUL_X;
                uc.base     = BASE_ACC;
                uc.op       = OP_SUB;
                uc.st_wr    = 1'b1;
                uc.st_k     = ST_Z0;
            end
            STEP_LOAD_B2X:
            begin
                uc.mul_sel = MUL_Y;
                uc.base    = BASE_ZERO;
                uc.op      = OP_ADD;
                uc.acc_en  = 1'b1;
            end
            STEP_WR_Z1:
            begin
                uc.base     = BASE_ACC;
                uc.op       = OP_SUB;
                uc.st_wr    = 1'b1;
                uc.st_k     = ST_Z1;
                uc.loop_end = 1'b1;
            end
            STEP_EMIT:
            begin
                uc.emit = 1'b1;
            end
            default:
            begin
                uc = UC_NOP;
            end
        endcase
        return uc;
    endfunction

endpackage

// File: rtl/biq_ram.sv
module biq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/biq_sequencer.sv
module biq_sequencer #(
    parameter int MAX_SECTIONS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [biq_pkg::ACT_W-1:0]       active_sections,
    input  logic                            out_free,
    output biq_pkg::ctrl_t                  ctrl,
    output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] sec,
    output logic                            busy,
    output logic                            emit
);

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int CW    = (CNT_W > biq_pkg::ACT_W) ? CNT_W : biq_pkg::ACT_W;

    biq_pkg::seq_mode_t                mode_reg, mode_next;
    logic [biq_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [SEC_W-1:0]                  sec_reg, sec_next;
    logic [CW-1:0]                     cnt_reg, cnt_next;
    logic [CW-1:0]                     act_w;
    logic [CW-1:0]                     n_eff;
    logic                              last_sec;
    biq_pkg::ucode_t                   uc;
    logic                              run;

    // Clamp the section count to what is built
    assign act_w = CW'(active_sections);
    assign n_eff = (act_w > CW'(MAX_SECTIONS)) ? CW'(MAX_SECTIONS) : act_w;

    assign uc       = biq_pkg::biq_ucode(step_reg);
    assign run      = (mode_reg == biq_pkg::SEQ_RUN);
    assign last_sec = ((CW'(sec_reg) + CW'(1)) == cnt_reg);

    // Next step, section and mode
    always_comb
    begin
        mode_next = mode_reg;
        step_next = step_reg;
        sec_next  = sec_reg;
        cnt_next  = cnt_reg;
        unique case (mode_reg)
            biq_pkg::SEQ_IDLE:
            begin
                if (start)
                begin
                    mode_next = biq_pkg::SEQ_RUN;
                    sec_next  = '0;
                    cnt_next  = n_eff;
                    step_next = (n_eff == '0) ? biq_pkg::STEP_EMIT : biq_pkg::STEP_FETCH;
                end
            end
            biq_pkg::SEQ_RUN:
            begin
                if (uc.loop_end)
                begin
                    if (last_sec)
                    begin
                        step_next = biq_pkg::STEP_EMIT;
                    end
                    else
                    begin
                        sec_next  = sec_reg + SEC_W'(1);
                        step_next = biq_pkg::STEP_FETCH;
                    end
                end
                else if (uc.emit)
                begin
                    if (out_free)
                    begin
                        mode_next = biq_pkg::SEQ_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + biq_pkg::STEP_W'(1);
                end
            end
            default:
            begin
                mode_next = biq_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= biq_pkg::SEQ_IDLE;
            step_reg <= biq_pkg::STEP_FETCH;
            sec_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            step_reg <= step_next;
            sec_reg  <= sec_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Drive the datapath from the current control word
    always_comb
    begin
        ctrl.start   = start;
        ctrl.advance = run && uc.loop_end;
        ctrl.uc      = run ? uc : biq_pkg::UC_NOP;
        emit         = run && uc.emit && out_free;
        busy         = run;
    end

    assign sec = sec_reg;

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        run |-> (step_reg <= biq_pkg::STEP_EMIT))
        else $error("step counter beyond end of program");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        (run && (step_reg != biq_pkg::STEP_EMIT)) |-> ((CW'(sec_reg) + CW'(1)) <= cnt_reg))
        else $error("section index beyond active count");

endmodule

// File: rtl/biq_datapath.sv
module biq_datapath #(
    parameter int MAX_SECTIONS    = 8,
    parameter int COEFF_FRAC_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  biq_pkg::ctrl_t                      ctrl,
    input  logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] sec,
    input  logic signed [biq_pkg::SMP_W-1:0]    sample,
    input  logic                                wr_en,
    input  logic [2:0]                          section,
    input  logic [2:0]                          coeff_index,
    input  logic signed [biq_pkg::COEF_W-1:0]   coeff_value,
    input  logic                                clr_en,
    output logic signed [biq_pkg::SMP_W-1:0]    filtered_sample,
    output logic                                overflow
);

    localparam int SMP_W  = biq_pkg::SMP_W;
    localparam int COEF_W = biq_pkg::COEF_W;
    localparam int ST_W   = biq_pkg::ST_W;
    localparam int PROD_W = biq_pkg::PROD_W;
    localparam int ACC_W  = biq_pkg::ACC_W;
    localparam int CDEPTH = MAX_SECTIONS * biq_pkg::NUM_COEFFS;
    localparam int CA_W   = $clog2(CDEPTH);
    localparam int SDEPTH = 2 * MAX_SECTIONS;
    localparam int SA_W   = $clog2(SDEPTH);

    localparam logic [COEF_W-1:0] UNIT_COEFF = (COEFF_FRAC_BITS >= COEF_W - 1) ?
        {1'b0, {(COEF_W-1){1'b1}}} : COEF_W'(64'(1) << COEFF_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'(1) << (COEFF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] ST_MAX  = {{(ACC_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN  = {{(ACC_W-ST_W+1){1'b1}}, {(ST_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SMP_MAX = {{(ACC_W-SMP_W+1){1'b0}}, {(SMP_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN = {{(ACC_W-SMP_W+1){1'b1}}, {(SMP_W-1){1'b0}}};

    // Coefficient store
    logic [CDEPTH-1:0]          cvalid_reg, cvalid_next;
    logic                       cvld_q_reg;
    logic                       cb0_q_reg;
    logic                       coef_we;
    logic [7:0]                 coef_wfull;
    logic [CA_W-1:0]            coef_waddr;
    logic [CA_W-1:0]            coef_raddr;
    logic [COEF_W-1:0]          coef_ram_q;
    logic signed [COEF_W-1:0]   coef_q;

    // Delay state store
    logic [SDEPTH-1:0]          svalid_reg, svalid_next;
    logic                       svld_q_reg;
    logic [SA_W-1:0]            st_addr;
    logic [ST_W-1:0]            st_ram_q;
    logic signed [ST_W-1:0]     st_q;
    logic [ST_W-1:0]            st_wdata;
    logic                       st_ovf;

    // Arithmetic
    logic signed [SMP_W-1:0]    x_reg;
    logic signed [SMP_W-1:0]    y_reg;
    logic signed [SMP_W-1:0]    opnd;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_base;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [ACC_W-1:0]    rnd;
    logic signed [ACC_W-1:0]    shf;
    logic signed [SMP_W-1:0]    y_sat;
    logic                       y_ovf;
    logic                       ovf_reg, ovf_next;

    // Coefficient write decode; out-of-range addresses are dropped
    assign coef_wfull = 8'(section) * 8'(biq_pkg::NUM_COEFFS) + 8'(coeff_index);
    assign coef_waddr = CA_W'(coef_wfull);
    assign coef_we    = wr_en && (6'(section) < 6'(MAX_SECTIONS))
                        && (coeff_index < 3'(biq_pkg::NUM_COEFFS));
    assign coef_raddr = CA_W'(sec) * CA_W'(biq_pkg::NUM_COEFFS) + CA_W'(ctrl.uc.coef_idx);

    biq_ram #(
        .WIDTH (COEF_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coeff_value),
        .re    (ctrl.uc.coef_rd),
        .raddr (coef_raddr),
        .rdata (coef_ram_q)
    );

    // Mark written coefficients; unwritten ones read as pass-through
    always_comb
    begin
        cvalid_next = cvalid_reg;
        if (coef_we)
        begin
            cvalid_next[coef_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= '0;
            cvld_q_reg <= 1'b0;
            cb0_q_reg  <= 1'b0;
        end
        else
        begin
            cvalid_reg <= cvalid_next;
            if (ctrl.uc.coef_rd)
            begin
                cvld_q_reg <= cvalid_reg[coef_raddr];
                cb0_q_reg  <= (ctrl.uc.coef_idx == biq_pkg::COEF_B0);
            end
        end
    end

    assign coef_q = cvld_q_reg ? coef_ram_q : (cb0_q_reg ? UNIT_COEFF : '0);

    // Delay state store
    assign st_addr = SA_W'({sec, ctrl.uc.st_k});

    biq_ram #(
        .WIDTH (ST_W),
        .DEPTH (SDEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ctrl.uc.st_wr),
        .waddr (st_addr),
        .wdata (st_wdata),
        .re    (ctrl.uc.st_rd),
        .raddr (st_addr),
        .rdata (st_ram_q)
    );

    // Clear drops every state at once; a write marks its entry
    always_comb
    begin
        svalid_next = svalid_reg;
        if (clr_en)
        begin
            svalid_next = '0;
        end
        else if (ctrl.uc.st_wr)
        begin
            svalid_next[st_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svalid_reg <= '0;
            svld_q_reg <= 1'b0;
        end
        else
        begin
            svalid_reg <= svalid_next;
            if (ctrl.uc.st_rd)
            begin
                svld_q_reg <= svalid_reg[st_addr];
            end
        end
    end

    assign st_q = svld_q_reg ? st_ram_q : '0;

    // Multiplier
    assign opnd      = (ctrl.uc.mul_sel == biq_pkg::MUL_Y) ? y_reg : x_reg;
    assign prod_next = PROD_W'(coef_q) * PROD_W'(opnd);
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Accumulator input: base plus or minus the product
    always_comb
    begin
        unique case (ctrl.uc.base)
            biq_pkg::BASE_ZERO:  acc_base = '0;
            biq_pkg::BASE_STATE: acc_base = {{(ACC_W-ST_W){st_q[ST_W-1]}}, st_q};
            default:             acc_base = acc_reg;
        endcase
        unique case (ctrl.uc.op)
            biq_pkg::OP_ADD: acc_sum = acc_base + prod_ext;
            biq_pkg::OP_SUB: acc_sum = acc_base - prod_ext;
            default:         acc_sum = acc_base;
        endcase
    end

    // Saturate a new delay state to 48 bits
    always_comb
    begin
        st_ovf = 1'b1;
        if (acc_sum > ST_MAX)
        begin
            st_wdata = {1'b0, {(ST_W-1){1'b1}}};
        end
        else if (acc_sum < ST_MIN)
        begin
            st_wdata = {1'b1, {(ST_W-1){1'b0}}};
        end
        else
        begin
            st_ovf   = 1'b0;
            st_wdata = acc_sum[ST_W-1:0];
        end
    end

    // Round half up, then saturate the section output
    assign rnd = acc_reg + HALF;
    assign shf = rnd >>> COEFF_FRAC_BITS;

    always_comb
    begin
        y_ovf = 1'b1;
        if (shf > SMP_MAX)
        begin
            y_sat = {1'b0, {(SMP_W-1){1'b1}}};
        end
        else if (shf < SMP_MIN)
        begin
            y_sat = {1'b1, {(SMP_W-1){1'b0}}};
        end
        else
        begin
            y_ovf = 1'b0;
            y_sat = shf[SMP_W-1:0];
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctrl.uc.acc_en)
        begin
            acc_reg <= acc_sum;
        end
        if (ctrl.uc.y_en)
        begin
            y_reg <= y_sat;
        end
        if (ctrl.start)
        begin
            x_reg <= sample;
        end
        else if (ctrl.advance)
        begin
            x_reg <= y_reg;
        end
    end

    // Collect saturation events over the whole request
    always_comb
    begin
        ovf_next = ovf_reg;
        if (ctrl.start)
        begin
            ovf_next = 1'b0;
        end
        else
        begin
            ovf_next = ovf_reg | (ctrl.uc.y_en & y_ovf) | (ctrl.uc.st_wr & st_ovf);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg <= 1'b0;
        end
        else
        begin
            ovf_reg <= ovf_next;
        end
    end

    assign filtered_sample = x_reg;
    assign overflow        = ovf_reg;

endmodule

// File: rtl/biquad_cascade_iir_filter.sv
// Cascade of second-order IIR sections, transposed direct form II, fixed point.
//
// Request channel (req_valid, req_stall, req_data): a request is taken at a
// clock edge with req_valid high and req_stall low. Command FILTER runs the
// sample through the active sections and gives one result on the result
// channel (res_valid, res_stall, res_data). WRITE stores one coefficient and
// CLEAR zeroes every delay state; neither makes the block busy and neither gives a result.
// The APB port holds active_sections at byte address 0; values above the
// number of built sections use all of them, zero passes samples through.
//
// Timing: a FILTER request with n active sections passes through them in turn;
// the next request is taken the cycle after the result is loaded into the
// output register. Each section is eight steps of the control program around
// one shared multiplier and accumulator.
//
// Reset empties the output register, sets active_sections to 0, loads b0 = 1.0
// and all other coefficients to 0, and zeroes all delay states. While the
// output register is full and stalled the block holds its next result in the
// final program step.
module biquad_cascade_iir_filter #(
    parameter int MAX_SECTIONS    = 8,
    parameter int COEFF_FRAC_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  biq_pkg::req_t                       req_data,
    output logic                                res_valid,
    input  logic                                res_stall,
    output biq_pkg::res_t                       res_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [biq_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [biq_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [biq_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

    logic [biq_pkg::ACT_W-1:0]      active_reg;
    logic                           req_accept;
    logic                           start;
    logic                           wr_en;
    logic                           clr_en;
    logic                           busy;
    logic                           emit;
    logic                           out_free;
    biq_pkg::ctrl_t                 ctrl;
    logic [SEC_W-1:0]               sec;
    logic signed [biq_pkg::SMP_W-1:0] dp_sample;
    logic                           dp_ovf;
    logic                           res_valid_reg, res_valid_next;
    biq_pkg::res_t                  res_data_reg;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            active_reg <= pwdata[biq_pkg::ACT_W-1:0];
        end
    end

    assign prdata = paddr[2] ? '0 : biq_pkg::APB_DATA_W'(active_reg);

    // Request decode
    assign req_stall  = busy;
    assign req_accept = req_valid && !busy;
    assign start      = req_accept && (req_data.command == biq_pkg::CMD_FILTER);
    assign wr_en      = req_accept && (req_data.command == biq_pkg::CMD_WRITE);
    assign clr_en     = req_accept && (req_data.command == biq_pkg::CMD_CLEAR);

    assign out_free = !res_valid_reg || !res_stall;

    biq_sequencer #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .active_sections (active_reg),
        .out_free        (out_free),
        .ctrl            (ctrl),
        .sec             (sec),
        .busy            (busy),
        .emit            (emit)
    );

    biq_datapath #(
        .MAX_SECTIONS    (MAX_SECTIONS),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .sec             (sec),
        .sample          (req_data.sample),
        .wr_en           (wr_en),
        .section         (req_data.section),
        .coeff_index     (req_data.coeff_index),
        .coeff_value     (req_data.coeff_value),
        .clr_en          (clr_en),
        .filtered_sample (dp_sample),
        .overflow        (dp_ovf)
    );

    // Output register: load on emit, drop once taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_data_reg.filtered_sample <= dp_sample;
            res_data_reg.overflow        <= dp_ovf;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(res_valid_reg && res_stall))
        else $error("result loaded over a stalled result");

    a_filter_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall && (req_data.command == biq_pkg::CMD_FILTER)) |=> busy)
        else $error("filter request did not start the sequencer");

endmodule
